@@ hdl/mtte_pkg.sv @@
// shared types, constants and texel expansion for the morton tiled texel expander
// no dependencies; imported by every module of the block
package mtte_pkg;

   // sizing
   localparam int MAX_DIMENSION = 1024;
   localparam int TILE_SIDE     = 8;
   localparam int DIM_W         = 11;
   localparam int PIX_W         = 10;
   localparam int RAW_W         = 32;
   localparam int CHAN_W        = 8;
   localparam int IN_TILE_W     = 6;
   localparam int TILE_IDX_W    = $clog2(MAX_DIMENSION / TILE_SIDE);
   localparam int TILE_CNT_W    = TILE_IDX_W + 1;
   localparam int POS_W         = TILE_IDX_W + 3;
   localparam int CSR_IDX_W     = 2;
   localparam int FMT_W         = 3;
   localparam int QUEUE_DEPTH   = 4;
   localparam int QPTR_W        = $clog2(QUEUE_DEPTH);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TEXEL_FORMAT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd2;

   // texel formats
   localparam logic [FMT_W-1:0] FMT_RGBA8888 = 3'd0;
   localparam logic [FMT_W-1:0] FMT_RGB888   = 3'd1;
   localparam logic [FMT_W-1:0] FMT_RGB565   = 3'd2;
   localparam logic [FMT_W-1:0] FMT_RGBA5551 = 3'd3;
   localparam logic [FMT_W-1:0] FMT_RGBA4444 = 3'd4;

   localparam logic [CHAN_W-1:0] CHAN_FULL = 8'd255;

   // live configuration with derived tile counts
   typedef struct packed {
      logic [FMT_W-1:0]      format;
      logic [DIM_W-1:0]      width_lim;
      logic [DIM_W-1:0]      height_lim;
      logic [TILE_CNT_W-1:0] cols;
      logic [TILE_CNT_W-1:0] rows;
   } cfg_type;

   // one visible texel waiting for expansion
   typedef struct packed {
      logic [POS_W-1:0] x;
      logic [POS_W-1:0] y;
      logic             last;
      logic [RAW_W-1:0] raw;
   } entry_type;

   typedef struct packed {
      logic [CHAN_W-1:0] r;
      logic [CHAN_W-1:0] g;
      logic [CHAN_W-1:0] b;
      logic [CHAN_W-1:0] a;
   } rgba_type;

   // clamp a dimension to the supported maximum
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] dim);
      logic [DIM_W-1:0] lim;
      lim = DIM_W'(MAX_DIMENSION);
      return (dim > lim) ? lim : dim;
   endfunction

   // tiles along a dimension after padding to a power of two, at least one
   function automatic logic [TILE_CNT_W-1:0] tile_count(input logic [DIM_W-1:0] dim);
      logic [DIM_W-1:0]      c;
      logic [TILE_CNT_W-1:0] p;
      c = clamp_dim(dim);
      p = TILE_CNT_W'(1);
      for (int i = 0; i < TILE_IDX_W; i++) begin
         if (DIM_W'({p, 3'b000}) < c) begin
            p = p << 1;
         end
      end
      return p;
   endfunction

   // raw texel to rgba8888 by bit replication
   function automatic rgba_type expand(input logic [FMT_W-1:0] fmt,
                                       input logic [RAW_W-1:0] raw);
      rgba_type c;
      case (fmt)
         FMT_RGB888: begin
            c.r = raw[23:16];
            c.g = raw[15:8];
            c.b = raw[7:0];
            c.a = CHAN_FULL;
         end
         FMT_RGB565: begin
            c.r = {raw[15:11], raw[15:13]};
            c.g = {raw[10:5], raw[10:9]};
            c.b = {raw[4:0], raw[4:2]};
            c.a = CHAN_FULL;
         end
         FMT_RGBA5551: begin
            c.r = {raw[15:11], raw[15:13]};
            c.g = {raw[10:6], raw[10:8]};
            c.b = {raw[5:1], raw[5:3]};
            c.a = raw[0] ? CHAN_FULL : '0;
         end
         FMT_RGBA4444: begin
            c.r = {raw[15:12], raw[15:12]};
            c.g = {raw[11:8], raw[11:8]};
            c.b = {raw[7:4], raw[7:4]};
            c.a = {raw[3:0], raw[3:0]};
         end
         default: begin
            c.r = raw[31:24];
            c.g = raw[23:16];
            c.b = raw[15:8];
            c.a = raw[7:0];
         end
      endcase
      return c;
   endfunction

endpackage

@@ hdl/mtte_front.sv @@
// front end: accepts texels, walks the tile position and drops invisible pixels
// depends on mtte_pkg; feeds mtte_queue
module mtte_front (
   input  logic                     clock,
   input  logic                     reset,
   input  mtte_pkg::cfg_type        cfg,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  logic [mtte_pkg::RAW_W-1:0] req_texel_raw,
   output logic                     push,
   output mtte_pkg::entry_type      push_entry
);
   import mtte_pkg::*;

   logic [IN_TILE_W-1:0]  texel_in_tile_ff, texel_in_tile_in;
   logic [TILE_IDX_W-1:0] tile_column_ff, tile_column_in;
   logic [TILE_IDX_W-1:0] tile_row_ff, tile_row_in;

   logic                  accept;
   logic [2:0]            lx, ly;
   logic [POS_W-1:0]      px, py;
   logic [TILE_CNT_W-1:0] col_inc, row_inc;
   logic                  tile_end, visible;

   assign accept = req_valid && !req_stall;

   // de-interleave the morton index and add the tile origin
   assign lx = {texel_in_tile_ff[4], texel_in_tile_ff[2], texel_in_tile_ff[0]};
   assign ly = {texel_in_tile_ff[5], texel_in_tile_ff[3], texel_in_tile_ff[1]};
   assign px = {tile_column_ff, lx};
   assign py = {tile_row_ff, ly};

   assign col_inc  = TILE_CNT_W'(tile_column_ff) + TILE_CNT_W'(1);
   assign row_inc  = TILE_CNT_W'(tile_row_ff) + TILE_CNT_W'(1);
   assign tile_end = (texel_in_tile_ff == '1);

   // classify the transaction
   assign visible = (DIM_W'(px) < cfg.width_lim) && (DIM_W'(py) < cfg.height_lim);
   assign push    = accept && visible;

   always_comb begin
      push_entry.x    = px;
      push_entry.y    = py;
      push_entry.last = tile_end && (col_inc >= cfg.cols) && (row_inc >= cfg.rows);
      push_entry.raw  = req_texel_raw;
   end

   // next position, wrapping by tile column, tile row and image
   always_comb begin
      texel_in_tile_in = texel_in_tile_ff + IN_TILE_W'(1);
      tile_column_in   = tile_column_ff;
      tile_row_in      = tile_row_ff;
      if (tile_end) begin
         if (col_inc >= cfg.cols) begin
            tile_column_in = '0;
            tile_row_in    = (row_inc >= cfg.rows) ? '0 : row_inc[TILE_IDX_W-1:0];
         end else begin
            tile_column_in = col_inc[TILE_IDX_W-1:0];
         end
      end
   end

   // position registers
   always_ff @(posedge clock) begin
      if (reset) begin
         texel_in_tile_ff <= '0;
         tile_column_ff   <= '0;
         tile_row_ff      <= '0;
      end else if (accept) begin
         texel_in_tile_ff <= texel_in_tile_in;
         tile_column_ff   <= tile_column_in;
         tile_row_ff      <= tile_row_in;
      end
   end

endmodule

@@ hdl/mtte_queue.sv @@
// short fifo between the front end and the expansion back end
// depends on mtte_pkg for the entry type and depth
module mtte_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  mtte_pkg::entry_type push_entry,
   input  logic                pop,
   output mtte_pkg::entry_type head_entry,
   output logic                not_empty,
   output logic                full
);
   import mtte_pkg::*;

   entry_type         store_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;

   assign not_empty  = (count_ff != '0);
   assign full       = (count_ff == (QPTR_W + 1)'(QUEUE_DEPTH));
   assign head_entry = store_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (QPTR_W + 1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (QPTR_W + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

@@ hdl/mtte_back.sv @@
// back end: expands the queued texel to rgba8888 into the result register
// depends on mtte_pkg; drains mtte_queue
module mtte_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [mtte_pkg::FMT_W-1:0]   format,
   input  mtte_pkg::entry_type          head_entry,
   input  logic                         not_empty,
   output logic                         pop,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [mtte_pkg::PIX_W-1:0]   rsp_pixel_x,
   output logic [mtte_pkg::PIX_W-1:0]   rsp_pixel_y,
   output logic [mtte_pkg::CHAN_W-1:0]  rsp_red,
   output logic [mtte_pkg::CHAN_W-1:0]  rsp_green,
   output logic [mtte_pkg::CHAN_W-1:0]  rsp_blue,
   output logic [mtte_pkg::CHAN_W-1:0]  rsp_alpha,
   output logic                         rsp_image_done
);
   import mtte_pkg::*;

   logic              valid_ff, valid_in;
   logic [PIX_W-1:0]  x_ff, y_ff;
   rgba_type          color_ff, color_in;
   logic              done_ff;

   // load the result register when it is empty or being taken
   assign pop      = not_empty && (!valid_ff || !rsp_stall);
   assign valid_in = pop || (valid_ff && rsp_stall);
   assign color_in = expand(format, head_entry.raw);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         x_ff     <= PIX_W'(head_entry.x);
         y_ff     <= PIX_W'(head_entry.y);
         color_ff <= color_in;
         done_ff  <= head_entry.last;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_pixel_x    = x_ff;
   assign rsp_pixel_y    = y_ff;
   assign rsp_red        = color_ff.r;
   assign rsp_green      = color_ff.g;
   assign rsp_blue       = color_ff.b;
   assign rsp_alpha      = color_ff.a;
   assign rsp_image_done = done_ff;

endmodule

@@ hdl/morton_tiled_texel_expand.sv @@
// Morton tiled texel expander, top level.
// Usage:
//   req channel: one raw texel per transaction (req_valid / req_stall), in
//   tiled stream order: 8x8 tiles row by row over the padded image, Morton
//   order inside a tile. Every accepted texel advances the position.
//   rsp channel: one rgba8888 pixel with its x/y for each texel inside the
//   visible width and height; texels in the padding give nothing.
//   rsp_image_done marks the pixel of the last texel of the padded image, if visible.
//   csr port: csr_we writes csr_wdata into register csr_index (0 format,
//   1 width, 2 height); write only while no transaction is in flight.
// Path: an accepted texel is written into the queue, then expanded into
//   the result register.
// Throughput: one texel per cycle; the front end only waits while the
//   4-entry queue is full, which needs rsp_stall held while the queue fills,
//   and it keeps waiting until the cycle after rsp_stall drops.
// Reset: synchronous; position returns to texel 0 of tile (0,0), format
//   rgba8888, width and height 8, queue and result register empty.
// A stalled result holds in the result register while the front end
//   keeps accepting into the queue until it fills.
// depends on mtte_pkg, mtte_front, mtte_queue, mtte_back
module morton_tiled_texel_expand (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_we,
   input  logic [mtte_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [mtte_pkg::DIM_W-1:0]   csr_wdata,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [mtte_pkg::RAW_W-1:0]   req_texel_raw,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [mtte_pkg::PIX_W-1:0]   rsp_pixel_x,
   output logic [mtte_pkg::PIX_W-1:0]   rsp_pixel_y,
   output logic [mtte_pkg::CHAN_W-1:0]  rsp_red,
   output logic [mtte_pkg::CHAN_W-1:0]  rsp_green,
   output logic [mtte_pkg::CHAN_W-1:0]  rsp_blue,
   output logic [mtte_pkg::CHAN_W-1:0]  rsp_alpha,
   output logic                         rsp_image_done
);
   import mtte_pkg::*;

   cfg_type   cfg_ff, cfg_in;
   logic      push, pop, not_empty, full;
   entry_type push_entry, head_entry;

   // configuration registers, tile counts derived at write time
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_TEXEL_FORMAT: cfg_in.format = csr_wdata[FMT_W-1:0];
            CSR_IMAGE_WIDTH: begin
               cfg_in.width_lim = clamp_dim(csr_wdata);
               cfg_in.cols      = tile_count(csr_wdata);
            end
            CSR_IMAGE_HEIGHT: begin
               cfg_in.height_lim = clamp_dim(csr_wdata);
               cfg_in.rows       = tile_count(csr_wdata);
            end
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.format     <= FMT_RGBA8888;
         cfg_ff.width_lim  <= DIM_W'(TILE_SIDE);
         cfg_ff.height_lim <= DIM_W'(TILE_SIDE);
         cfg_ff.cols       <= TILE_CNT_W'(1);
         cfg_ff.rows       <= TILE_CNT_W'(1);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_stall = full;

   mtte_front u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_texel_raw (req_texel_raw),
      .push          (push),
      .push_entry    (push_entry)
   );

   mtte_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .not_empty  (not_empty),
      .full       (full)
   );

   mtte_back u_back (
      .clock          (clock),
      .reset          (reset),
      .format         (cfg_ff.format),
      .head_entry     (head_entry),
      .not_empty      (not_empty),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_pixel_x    (rsp_pixel_x),
      .rsp_pixel_y    (rsp_pixel_y),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue),
      .rsp_alpha      (rsp_alpha),
      .rsp_image_done (rsp_image_done)
   );

endmodule

@@ tb/sv/morton_tiled_texel_expand_test.sv @@
// self-checking testbench for morton_tiled_texel_expand: tiled texel stream in, rgba8888 pixels out
// predicts every pixel from its own tile walk and channel expansion; depends on mtte_pkg and morton_tiled_texel_expand
typedef struct packed {
   logic [mtte_pkg::PIX_W-1:0]  x;
   logic [mtte_pkg::PIX_W-1:0]  y;
   logic [mtte_pkg::CHAN_W-1:0] red;
   logic [mtte_pkg::CHAN_W-1:0] green;
   logic [mtte_pkg::CHAN_W-1:0] blue;
   logic [mtte_pkg::CHAN_W-1:0] alpha;
   logic                        image_done;
} pixel_type;

// tracks tile position and format, predicts pixels and matches them in order
class morton_pixel_tracker;
   logic [mtte_pkg::FMT_W-1:0] format;
   logic [mtte_pkg::DIM_W-1:0] width;
   logic [mtte_pkg::DIM_W-1:0] height;
   logic [5:0]                 texel_idx;
   logic [6:0]                 tile_col;
   logic [6:0]                 tile_row;
   pixel_type                  due_pixels[$];
   int unsigned                mismatches;

   function new();
      format     = mtte_pkg::FMT_RGBA8888;
      width      = 11'd8;
      height     = 11'd8;
      texel_idx  = '0;
      tile_col   = '0;
      tile_row   = '0;
      mismatches = 0;
   endfunction

   function void write_reg(logic [mtte_pkg::CSR_IDX_W-1:0] idx,
                           logic [mtte_pkg::DIM_W-1:0] value);
      case (idx)
         mtte_pkg::CSR_TEXEL_FORMAT: format = value[mtte_pkg::FMT_W-1:0];
         mtte_pkg::CSR_IMAGE_WIDTH:  width  = value;
         mtte_pkg::CSR_IMAGE_HEIGHT: height = value;
         default: ;
      endcase
   endfunction

   // visible extent after clamping to the largest supported size
   static function int unsigned visible_span(logic [mtte_pkg::DIM_W-1:0] dim);
      return (dim > mtte_pkg::MAX_DIMENSION) ? mtte_pkg::MAX_DIMENSION : dim;
   endfunction

   // power-of-two padded extent in tiles, never below one tile
   static function int unsigned tiles_across(logic [mtte_pkg::DIM_W-1:0] dim);
      int unsigned span;
      span = 8;
      while (span < visible_span(dim))
         span = span * 2;
      return span / 8;
   endfunction

   static function logic [7:0] widen5(logic [4:0] v);
      return {v, v[4:2]};
   endfunction

   static function logic [7:0] widen6(logic [5:0] v);
      return {v, v[5:4]};
   endfunction

   static function logic [7:0] widen4(logic [3:0] v);
      return {v, v};
   endfunction

   function void accept_texel(logic [31:0] raw);
      int unsigned cols;
      int unsigned rows;
      int unsigned col_x;
      int unsigned row_y;
      logic [2:0]  lx;
      logic [2:0]  ly;
      pixel_type   p;
      cols  = tiles_across(width);
      rows  = tiles_across(height);
      // morton index: even bits carry x, odd bits carry y
      lx    = {texel_idx[4], texel_idx[2], texel_idx[0]};
      ly    = {texel_idx[5], texel_idx[3], texel_idx[1]};
      col_x = tile_col * 8 + lx;
      row_y = tile_row * 8 + ly;
      if (col_x < visible_span(width) && row_y < visible_span(height)) begin
         p.x          = mtte_pkg::PIX_W'(col_x);
         p.y          = mtte_pkg::PIX_W'(row_y);
         p.image_done = (texel_idx == 6'd63) && (tile_col + 1 >= cols)
                        && (tile_row + 1 >= rows);
         case (format)
            mtte_pkg::FMT_RGB888: begin
               p.red   = raw[23:16];
               p.green = raw[15:8];
               p.blue  = raw[7:0];
               p.alpha = 8'hFF;
            end
            mtte_pkg::FMT_RGB565: begin
               p.red   = widen5(raw[15:11]);
               p.green = widen6(raw[10:5]);
               p.blue  = widen5(raw[4:0]);
               p.alpha = 8'hFF;
            end
            mtte_pkg::FMT_RGBA5551: begin
               p.red   = widen5(raw[15:11]);
               p.green = widen5(raw[10:6]);
               p.blue  = widen5(raw[5:1]);
               p.alpha = raw[0] ? 8'hFF : 8'h00;
            end
            mtte_pkg::FMT_RGBA4444: begin
               p.red   = widen4(raw[15:12]);
               p.green = widen4(raw[11:8]);
               p.blue  = widen4(raw[7:4]);
               p.alpha = widen4(raw[3:0]);
            end
            // rgba8888 and the unused codes
            default: begin
               p.red   = raw[31:24];
               p.green = raw[23:16];
               p.blue  = raw[15:8];
               p.alpha = raw[7:0];
            end
         endcase
         due_pixels.push_back(p);
      end
      // step the position; out-of-range tiles after a resize wrap on the next tile step
      texel_idx = texel_idx + 6'd1;
      if (texel_idx == 6'd0) begin
         if (tile_col + 1 >= cols) begin
            tile_col = '0;
            if (tile_row + 1 >= rows)
               tile_row = '0;
            else
               tile_row = tile_row + 7'd1;
         end else begin
            tile_col = tile_col + 7'd1;
         end
      end
   endfunction

   function void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   function void compare_pixel(pixel_type got);
      pixel_type want;
      if (due_pixels.size() == 0) begin
         $error("pixel at x %0d y %0d arrived with none predicted", got.x, got.y);
         mismatches++;
         return;
      end
      want = due_pixels.pop_front();
      check_field("pixel_x", want.x, got.x);
      check_field("pixel_y", want.y, got.y);
      check_field("red", want.red, got.red);
      check_field("green", want.green, got.green);
      check_field("blue", want.blue, got.blue);
      check_field("alpha", want.alpha, got.alpha);
      check_field("image_done", want.image_done, got.image_done);
   endfunction
endclass

module morton_tiled_texel_expand_test;
   import mtte_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE       = 2'd3;
   localparam logic [FMT_W-1:0]     FMT_UNUSED_LAST = 3'd7;
   localparam int IDLE_LIMIT    = 2000;
   localparam int SETTLE_CYCLES = 4;
   localparam int RANDOM_TEXELS = 1200;

   // directed sizes, one pair per format code
   localparam logic [DIM_W-1:0] DIRECTED_WIDTHS  [8] = '{11'd8, 11'd1, 11'd1024, 11'd2047,
                                                         11'd0, 11'd3, 11'd1025, 11'd1};
   localparam logic [DIM_W-1:0] DIRECTED_HEIGHTS [8] = '{11'd8, 11'd1024, 11'd1, 11'd2047,
                                                         11'd5, 11'd0, 11'd8, 11'd1};

   logic                 clock         = 1'b0;
   logic                 reset         = 1'b1;
   logic                 csr_we        = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index     = '0;
   logic [DIM_W-1:0]     csr_wdata     = '0;
   logic                 req_valid     = 1'b0;
   logic                 req_stall;
   logic [RAW_W-1:0]     req_texel_raw = '0;
   logic                 rsp_valid;
   logic                 rsp_stall     = 1'b0;
   logic [PIX_W-1:0]     rsp_pixel_x;
   logic [PIX_W-1:0]     rsp_pixel_y;
   logic [CHAN_W-1:0]    rsp_red;
   logic [CHAN_W-1:0]    rsp_green;
   logic [CHAN_W-1:0]    rsp_blue;
   logic [CHAN_W-1:0]    rsp_alpha;
   logic                 rsp_image_done;

   morton_pixel_tracker tracker;
   pixel_type           seen_pixel;
   int                  stall_left    = 0;
   bit                  steady_drain  = 1'b0;
   bit                  steady_feed   = 1'b0;
   int                  idle_cycles   = 0;

   morton_tiled_texel_expand u_dut (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_texel_raw  (req_texel_raw),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_pixel_x    (rsp_pixel_x),
      .rsp_pixel_y    (rsp_pixel_y),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue),
      .rsp_alpha      (rsp_alpha),
      .rsp_image_done (rsp_image_done)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // result side: check each pixel transaction, then draw a stall for the next one
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            seen_pixel = '{rsp_pixel_x, rsp_pixel_y, rsp_red, rsp_green, rsp_blue,
                           rsp_alpha, rsp_image_done};
            tracker.compare_pixel(seen_pixel);
            if ($urandom_range(0, 15) == 0)
               steady_drain = !steady_drain;
            stall_left = steady_drain ? 0 : $urandom_range(0, 8);
         end
         if (stall_left != 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // watchdog on cycles without any transaction or register write
   always @(posedge clock) begin
      if (reset || csr_we || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   // one texel transaction after a random gap; valid stays high into the next one
   task automatic send_texel(input logic [RAW_W-1:0] raw);
      int gap;
      if ($urandom_range(0, 15) == 0)
         steady_feed = !steady_feed;
      gap = steady_feed ? 0 : $urandom_range(0, 8);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_texel_raw <= raw;
      do @(posedge clock); while (req_stall);
      tracker.accept_texel(raw);
   endtask

   // stop feeding, collect every predicted pixel, then let the pipeline empty
   task automatic settle_idle();
      req_valid <= 1'b0;
      while (tracker.due_pixels.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // write format, width and height, optionally the spare index too
   task automatic apply_setup(input logic [FMT_W-1:0] fmt, input logic [DIM_W-1:0] w,
                              input logic [DIM_W-1:0] h, input bit touch_spare);
      logic [CSR_IDX_W-1:0] idxs [4];
      logic [DIM_W-1:0]     vals [4];
      idxs = '{CSR_TEXEL_FORMAT, CSR_IMAGE_WIDTH, CSR_IMAGE_HEIGHT, CSR_SPARE};
      vals = '{DIM_W'(fmt), w, h, DIM_W'($urandom)};
      for (int i = 0; i < (touch_spare ? 4 : 3); i++) begin
         csr_we    <= 1'b1;
         csr_index <= idxs[i];
         csr_wdata <= vals[i];
         @(posedge clock);
         tracker.write_reg(idxs[i], vals[i]);
      end
      csr_we <= 1'b0;
   endtask

   function automatic logic [RAW_W-1:0] pick_raw();
      case ($urandom_range(0, 9))
         0:       return '1;
         1:       return '0;
         default: return $urandom;
      endcase
   endfunction

   // extremes and odd sizes for wide phases, one or two tiles otherwise
   function automatic logic [DIM_W-1:0] pick_dim(input bit roomy);
      if (!roomy)
         return DIM_W'($urandom_range(1, 16));
      case ($urandom_range(0, 9))
         0:       return 11'd0;
         1:       return 11'd1;
         2:       return 11'd7;
         3:       return 11'd8;
         4:       return 11'd9;
         5:       return 11'd1023;
         6:       return 11'd1024;
         7:       return 11'd1025;
         8:       return 11'd2047;
         default: return DIM_W'($urandom_range(0, 2047));
      endcase
   endfunction

   initial begin : stimulus
      int               texels_sent;
      int               burst;
      bit               roomy;
      logic [DIM_W-1:0] w;
      logic [DIM_W-1:0] h;
      tracker = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: every format code with full, empty and mixed texels at extreme sizes
      for (int f = FMT_RGBA8888; f <= FMT_UNUSED_LAST; f++) begin
         apply_setup(FMT_W'(f), DIRECTED_WIDTHS[f], DIRECTED_HEIGHTS[f], f == FMT_UNUSED_LAST);
         send_texel(32'hFFFF_FFFF);
         send_texel(32'h0000_0000);
         send_texel(32'hA53C_96F1);
         settle_idle();
      end

      // random phases; small images run a whole padded pass so wrap and image_done occur
      texels_sent = 0;
      while (texels_sent < RANDOM_TEXELS) begin
         roomy = ($urandom_range(0, 2) == 0);
         w     = pick_dim(roomy);
         h     = pick_dim(roomy);
         apply_setup(FMT_W'($urandom_range(FMT_RGBA8888, FMT_UNUSED_LAST)), w, h, 1'b0);
         if (roomy)
            burst = $urandom_range(8, 150);
         else
            burst = 64 * tracker.tiles_across(w) * tracker.tiles_across(h)
                    + $urandom_range(0, 20);
         repeat (burst) send_texel(pick_raw());
         texels_sent += burst;
         settle_idle();
      end

      if (tracker.mismatches == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

@@ morton_tiled_texel_expand.f @@
hdl/mtte_pkg.sv
hdl/mtte_front.sv
hdl/mtte_queue.sv
hdl/mtte_back.sv
hdl/morton_tiled_texel_expand.sv
tb/sv/morton_tiled_texel_expand_test.sv
